// ===== hdl/dps_pkg.sv =====
// Shared types, constants and the voltage-to-distance table of the distance PID step.
`default_nettype none
package dps_pkg;

  localparam int FRAC_BITS     = 8;
  localparam int INTEGRAL_BITS = 32;

  localparam int VOLT_W   = 12;
  localparam int DIST_W   = 8;
  localparam int ERR_W    = 9;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int MAG_W    = ERR_W;
  localparam int NUM_W    = MAG_W + FRAC_BITS;
  localparam int DT_W     = 10;
  localparam int GAIN_W   = 8;
  localparam int QDRV_W   = NUM_W + 1;
  localparam int DERIV_W  = 18;
  localparam int OUT_DRV_W = 48;
  localparam int LED_W    = 2;

  localparam int MUL_A_W  = INTEGRAL_BITS + 1;
  localparam int MUL_B_W  = DT_W + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int DRV_W    = PROD_W + FRAC_BITS;

  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd4;

  localparam logic [LED_W-1:0] LED_BLUE  = 2'd0;
  localparam logic [LED_W-1:0] LED_RED   = 2'd1;
  localparam logic [LED_W-1:0] LED_GREEN = 2'd2;

  localparam int EDGE_COUNT = 14;
  localparam logic [VOLT_W-1:0] VOLT_EDGE [EDGE_COUNT] = '{
    12'd1500, 12'd1200, 12'd1000, 12'd700, 12'd600, 12'd500, 12'd450,
    12'd400, 12'd375, 12'd350, 12'd325, 12'd300, 12'd275, 12'd250
  };
  localparam logic [DIST_W-1:0] DIST_OF [EDGE_COUNT] = '{
    8'd0, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70,
    8'd80, 8'd90, 8'd100, 8'd110, 8'd120, 8'd130, 8'd140
  };
  localparam logic [DIST_W-1:0] DIST_FLOOR = 8'd150;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_MUL_E,
    OP_INTEG,
    OP_DIV,
    OP_SIGN,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_ADD_D,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // The first edge that the voltage exceeds picks the bucket.
  function automatic logic [DIST_W-1:0] lookup_distance(input logic [VOLT_W-1:0] mv);
    logic [DIST_W-1:0] d;
    d = DIST_FLOOR;
    for (int i = EDGE_COUNT - 1; i >= 0; i--) begin
      if (mv > VOLT_EDGE[i]) d = DIST_OF[i];
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/dps_ctrl.sv =====
// Distance PID sequencer: one datapath op per cycle, held while output stalls.
`default_nettype none
module dps_ctrl
  import dps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          busy,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_E, S_INTEG, S_DIV, S_SIGN,
    S_MUL_P, S_MUL_I, S_MUL_D, S_ADD_D, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_MUL_E;
          busy_nxt  = 1'b1;
        end
      end
      S_MUL_E: begin
        cmd.op    = OP_MUL_E;
        state_nxt = S_INTEG;
      end
      S_INTEG: begin
        cmd.op    = OP_INTEG;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_SIGN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SIGN: begin
        cmd.op    = OP_SIGN;
        state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.op    = OP_MUL_P;
        state_nxt = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.op    = OP_MUL_I;
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.op    = OP_MUL_D;
        state_nxt = S_ADD_D;
      end
      S_ADD_D: begin
        cmd.op    = OP_ADD_D;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

// ===== hdl/dps_datapath.sv =====
// Datapath of the distance PID step: configuration, state, shared multiplier and divider.
`default_nettype none
module dps_datapath
  import dps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [VOLT_W-1:0]     in_voltage_mv,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [DIST_W-1:0]          out_distance_cm,
  output logic signed [ERR_W-1:0]    out_error_value,
  output logic signed [INTEGRAL_BITS-1:0] out_integral_sum,
  output logic signed [DERIV_W-1:0]  out_derivative_q8,
  output logic signed [OUT_DRV_W-1:0] out_drive_q8,
  output logic [LED_W-1:0]           out_led_code
);

  // Configuration registers.
  logic [DIST_W-1:0]        setpoint_r;
  logic [DT_W-1:0]          step_r;
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= DIST_W'(50);
      step_r     <= DT_W'(100);
      gain_p_r   <= GAIN_W'(1);
      gain_i_r   <= GAIN_W'(1);
      gain_d_r   <= GAIN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETPOINT: setpoint_r <= cfg_data[DIST_W-1:0];
        CFG_STEP:     step_r     <= cfg_data[DT_W-1:0];
        CFG_GAIN_P:   gain_p_r   <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:   gain_i_r   <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:   gain_d_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Loop state.
  logic signed [INTEGRAL_BITS-1:0] integ_r;
  logic signed [ERR_W-1:0]         last_err_r;

  // Working registers.
  logic [DIST_W-1:0]        dist_r;
  logic signed [ERR_W-1:0]  err_r;
  logic                     neg_r;
  logic [DT_W-1:0]          den_r;
  logic [DT_W-1:0]          rem_r;
  logic [NUM_W-1:0]         quo_r;
  logic signed [QDRV_W-1:0] deriv_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DRV_W-1:0]  drive_r;

  // Lookup and error from the incoming voltage.
  logic [DIST_W-1:0]       dist_in;
  logic signed [ERR_W-1:0] err_in;
  assign dist_in = lookup_distance(in_voltage_mv);
  assign err_in  = $signed({1'b0, setpoint_r}) - $signed({1'b0, dist_in});

  // Difference against the previous error and its magnitude.
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;
  assign diff     = $signed({err_r[ERR_W-1], err_r}) -
                    $signed({last_err_r[ERR_W-1], last_err_r});
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // Integral update with saturation.
  logic signed [INTEGRAL_BITS:0] acc_sum;
  logic signed [INTEGRAL_BITS-1:0] acc_sat;
  assign acc_sum = $signed({integ_r[INTEGRAL_BITS-1], integ_r}) +
                   $signed(prod_r[INTEGRAL_BITS:0]);
  always_comb begin
    if (acc_sum[INTEGRAL_BITS] != acc_sum[INTEGRAL_BITS-1]) begin
      acc_sat = acc_sum[INTEGRAL_BITS] ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
                                       : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[INTEGRAL_BITS-1:0];
    end
  end

  // One restoring divide step.
  logic [DT_W:0]   shifted;
  logic [DT_W+1:0] trial;
  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};

  // Shared multiplier operands.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  always_comb begin
    mul_a = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
    mul_b = {1'b0, step_r};
    case (cmd.op)
      OP_MUL_P: mul_b = {{(MUL_B_W-GAIN_W){gain_p_r[GAIN_W-1]}}, gain_p_r};
      OP_MUL_I: begin
        mul_a = {integ_r[INTEGRAL_BITS-1], integ_r};
        mul_b = {{(MUL_B_W-GAIN_W){gain_i_r[GAIN_W-1]}}, gain_i_r};
      end
      OP_MUL_D: begin
        mul_a = {{(MUL_A_W-QDRV_W){deriv_r[QDRV_W-1]}}, deriv_r};
        mul_b = {{(MUL_B_W-GAIN_W){gain_d_r[GAIN_W-1]}}, gain_d_r};
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic signed [DRV_W-1:0] prod_scaled, prod_plain;
  assign prod_scaled = {prod_r, {FRAC_BITS{1'b0}}};
  assign prod_plain  = {{FRAC_BITS{prod_r[PROD_W-1]}}, prod_r};

  // Drive saturation to the output width.
  logic signed [OUT_DRV_W-1:0] drive_sat;
  logic                        drive_fits;
  assign drive_fits = (drive_r[DRV_W-1:OUT_DRV_W-1] == '0) ||
                      (drive_r[DRV_W-1:OUT_DRV_W-1] == '1);
  always_comb begin
    if (drive_fits) begin
      drive_sat = drive_r[OUT_DRV_W-1:0];
    end else begin
      drive_sat = drive_r[DRV_W-1] ? {1'b1, {(OUT_DRV_W-1){1'b0}}}
                                   : {1'b0, {(OUT_DRV_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
    end else if (cmd.op == OP_INTEG) begin
      integ_r    <= acc_sat;
      last_err_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        dist_r <= dist_in;
        err_r  <= err_in;
      end
      OP_MUL_E, OP_MUL_P: prod_r <= mul_p;
      OP_INTEG: begin
        neg_r <= diff[DIFF_W-1];
        den_r <= (step_r == '0) ? DT_W'(1) : step_r;
        rem_r <= '0;
        quo_r <= {diff_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
      end
      OP_DIV: begin
        if (!trial[DT_W+1]) begin
          rem_r <= trial[DT_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[DT_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
      end
      OP_SIGN: deriv_r <= neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
      OP_MUL_I: begin
        prod_r  <= mul_p;
        drive_r <= prod_scaled;
      end
      OP_MUL_D: begin
        prod_r  <= mul_p;
        drive_r <= drive_r + prod_scaled;
      end
      OP_ADD_D: drive_r <= drive_r + prod_plain;
      default: ;
    endcase
  end

  // Output register.
  logic out_valid_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_distance_cm   <= dist_r;
      out_error_value   <= err_r;
      out_integral_sum  <= integ_r;
      out_derivative_q8 <= DERIV_W'(deriv_r);
      out_drive_q8      <= drive_sat;
      if (err_r == '0) begin
        out_led_code <= LED_GREEN;
      end else if (err_r[ERR_W-1]) begin
        out_led_code <= LED_RED;
      end else begin
        out_led_code <= LED_BLUE;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== hdl/distance_pid_step.sv =====
// Each item runs through the sequencer's states, including the 17-step serial divider, before its result is valid.
// A new input transfer is taken only once the previous result is loaded, so items do not overlap.
// A stalled result waits in the output register while the next item is accepted and worked.
// Reset (rst_n low, synchronous) clears the integral and last error, reloads the
// configuration defaults and empties the output register; no clearing pass is needed.
`default_nettype none
module distance_pid_step
  import dps_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [VOLT_W-1:0]          in_voltage_mv,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [DIST_W-1:0]               out_distance_cm,
  output logic signed [ERR_W-1:0]         out_error_value,
  output logic signed [INTEGRAL_BITS-1:0] out_integral_sum,
  output logic signed [DERIV_W-1:0]       out_derivative_q8,
  output logic signed [OUT_DRV_W-1:0]     out_drive_q8,
  output logic [LED_W-1:0]                out_led_code
);

  // The sequencer walks one item through lookup, the error-times-step product,
  // the integral update, the divide for the derivative and three gain products
  // that share one multiplier. Its busy flag is the input stall: the input
  // transfer happens only in the idle state.
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy;

  dps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .busy     (busy),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the loop state and the output
  // register. The result is loaded only when that register is free, so a
  // waiting result is never overwritten.
  dps_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_voltage_mv     (in_voltage_mv),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_distance_cm   (out_distance_cm),
    .out_error_value   (out_error_value),
    .out_integral_sum  (out_integral_sum),
    .out_derivative_q8 (out_derivative_q8),
    .out_drive_q8      (out_drive_q8),
    .out_led_code      (out_led_code)
  );

  assign in_stall = busy;

`ifndef ASSERT_OFF
  // After an input transfer the block is busy with that item.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  // The green code appears exactly when the error is zero.
  a_led_green: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_led_code == LED_GREEN) == (out_error_value == '0)))
    else $error("led code disagrees with error");

  // The red code appears exactly when the error is negative.
  a_led_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_led_code == LED_RED) == out_error_value[ERR_W-1]))
    else $error("led code disagrees with error sign");

  // The distance bucket never exceeds the table floor.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance_cm <= DIST_FLOOR))
    else $error("distance out of range");
`endif

endmodule
`default_nettype wire
